/* rtl/core/ccnt_pkg.sv */
package ccnt_pkg;

    localparam int LOC_DEPTH = 1024;
    localparam int LOC_AW = 10;
    localparam int CLU_DEPTH = 64;
    localparam int CLU_AW = 6;
    localparam int CNT_W = 21;
    localparam int SUM_W = 32;
    localparam int TALLY_W = 32;
    localparam int LOC_W = 85;
    localparam int CLU_W = 64;

    localparam logic [2:0] F_LOAD_LOC = 3'd0;
    localparam logic [2:0] F_LOAD_CLU = 3'd1;
    localparam logic [2:0] F_LABEL = 3'd2;
    localparam logic [2:0] F_END_SIM = 3'd3;
    localparam logic [2:0] F_READ_TALLY = 3'd4;

    localparam logic CFG_LOC_COUNT = 1'b0;
    localparam logic CFG_CLU_COUNT = 1'b1;

    localparam logic KIND_EVAL = 1'b0;
    localparam logic KIND_TALLY = 1'b1;

    typedef struct packed {
        logic [2:0] func;
        logic [9:0] index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [20:0] end_index;
        logic [9:0] center_index;
        logic [31:0] radius;
        logic [20:0] observed_cases;
        logic high_flag;
        logic case_label;
    } in_t;

    typedef struct packed {
        logic result_kind;
        logic [5:0] cluster_id;
        logic [31:0] extreme_tally;
    } out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_L_READ,
        ST_L_CHK,
        ST_L_INC,
        ST_L_FIN,
        ST_T_READ,
        ST_E_CLU,
        ST_E_CLU_W,
        ST_E_CEN,
        ST_E_SCAN,
        ST_E_DRAIN,
        ST_E_DONE
    } state_t;

endpackage

/* rtl/core/ccnt_ram.sv */
module ccnt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/ccnt_dist.sv */
module ccnt_dist (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           vld,
    input  logic [31:0]                    x,
    input  logic [31:0]                    y,
    input  logic [31:0]                    cx,
    input  logic [31:0]                    cy,
    input  logic [63:0]                    r2,
    input  logic [ccnt_pkg::CNT_W-1:0]     cases,
    output logic                           hit_vld,
    output logic [ccnt_pkg::CNT_W-1:0]     hit_cases,
    output logic                           busy
);

    logic                       d_vld_reg;
    logic [31:0]                dx_reg;
    logic [31:0]                dy_reg;
    logic [ccnt_pkg::CNT_W-1:0] d_cases_reg;
    logic                       m_vld_reg;
    logic [63:0]                a_reg;
    logic [63:0]                b_reg;
    logic [ccnt_pkg::CNT_W-1:0] m_cases_reg;
    logic signed [32:0]         dx;
    logic signed [32:0]         dy;
    logic [32:0]                dx_abs;
    logic [32:0]                dy_abs;
    logic [64:0]                s;

    always_comb
    begin
        dx = $signed({x[31], x}) - $signed({cx[31], cx});
        dy = $signed({y[31], y}) - $signed({cy[31], cy});
        dx_abs = dx[32] ? 33'(-dx) : 33'(dx);
        dy_abs = dy[32] ? 33'(-dy) : 33'(dy);
        s = {1'b0, a_reg} + {1'b0, b_reg};
        hit_vld = m_vld_reg;
        hit_cases = (s <= {1'b0, r2}) ? m_cases_reg : '0;
        busy = d_vld_reg | m_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= vld;
            m_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_abs[31:0];
        dy_reg <= dy_abs[31:0];
        d_cases_reg <= cases;
        a_reg <= 64'(dx_reg) * 64'(dx_reg);
        b_reg <= 64'(dy_reg) * 64'(dy_reg);
        m_cases_reg <= d_cases_reg;
    end

endmodule

/* rtl/core/circular_cluster_null_tally_top.sv */
// Channel  | Signals                        | Payload
// input    | in_valid, in_ready, in_data    | ccnt_pkg::in_t
// output   | out_valid, out_ready, out_data | ccnt_pkg::out_t
// config   | cfg_we, cfg_index, cfg_data    | 11-bit register data
//
// Loads finish in idle; a tally read passes ST_T_READ. A label runs ST_L_READ
// and ST_L_CHK for each location its position passes, then ST_L_INC for a case
// label and ST_L_FIN. End of simulation reads every location once per cluster
// with a valid center, paced by the single location memory read port, then
// clears all 1024 case counts, a sweep also run after reset with no input taken.
// A new item is taken only in idle and when the output register is free.
module circular_cluster_null_tally_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ccnt_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ccnt_pkg::out_t  out_data,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [10:0]     cfg_data
);

    ccnt_pkg::state_t state_reg, state_next;
    logic [10:0] loc_cnt_reg;
    logic [6:0]  clu_cnt_reg;
    logic [20:0] pos_reg, pos_next;
    logic [10:0] cur_reg, cur_next;
    logic        label_reg, label_next;
    logic        eval_reg, eval_next;
    logic [9:0]  clr_reg, clr_next;
    logic [5:0]  j_reg, j_next;
    logic [9:0]  k_reg, k_next;
    logic [5:0]  tid_reg, tid_next;
    logic        trange_reg, trange_next;
    logic [63:0] tvld_reg, tvld_next;
    logic        iss_reg, iss_next;
    logic        out_vld_reg, out_vld_next;
    ccnt_pkg::out_t out_reg, out_next;
    logic [31:0] rad_reg, rad_next;
    logic [20:0] obs_reg, obs_next;
    logic        high_reg, high_next;
    logic [31:0] tcur_reg, tcur_next;
    logic [31:0] cx_reg, cx_next;
    logic [31:0] cy_reg, cy_next;
    logic [63:0] r2_reg, r2_next;
    logic [ccnt_pkg::SUM_W-1:0] sum_reg, sum_next;

    logic [10:0] nl;
    logic [6:0]  nc;
    logic        hit;

    logic                        loc_we;
    logic [9:0]                  loc_waddr, loc_raddr;
    logic [ccnt_pkg::LOC_W-1:0]  loc_wdata, loc_q;
    logic                        cas_we;
    logic [9:0]                  cas_waddr, cas_raddr;
    logic [20:0]                 cas_wdata, cas_q;
    logic                        clu_we;
    logic [5:0]                  clu_waddr, clu_raddr;
    logic [ccnt_pkg::CLU_W-1:0]  clu_wdata, clu_q;
    logic                        tal_we;
    logic [5:0]                  tal_waddr, tal_raddr;
    logic [31:0]                 tal_wdata, tal_q;
    logic                        d_hit_vld;
    logic [20:0]                 d_hit_cases;
    logic                        d_busy;

    ccnt_ram #(.WIDTH(ccnt_pkg::LOC_W), .DEPTH(ccnt_pkg::LOC_DEPTH)) u_loc_ram (
        .clk(clk), .we(loc_we), .waddr(loc_waddr), .wdata(loc_wdata),
        .raddr(loc_raddr), .rdata(loc_q)
    );

    ccnt_ram #(.WIDTH(ccnt_pkg::CNT_W), .DEPTH(ccnt_pkg::LOC_DEPTH)) u_cas_ram (
        .clk(clk), .we(cas_we), .waddr(cas_waddr), .wdata(cas_wdata),
        .raddr(cas_raddr), .rdata(cas_q)
    );

    ccnt_ram #(.WIDTH(ccnt_pkg::CLU_W), .DEPTH(ccnt_pkg::CLU_DEPTH)) u_clu_ram (
        .clk(clk), .we(clu_we), .waddr(clu_waddr), .wdata(clu_wdata),
        .raddr(clu_raddr), .rdata(clu_q)
    );

    ccnt_ram #(.WIDTH(ccnt_pkg::TALLY_W), .DEPTH(ccnt_pkg::CLU_DEPTH)) u_tal_ram (
        .clk(clk), .we(tal_we), .waddr(tal_waddr), .wdata(tal_wdata),
        .raddr(tal_raddr), .rdata(tal_q)
    );

    ccnt_dist u_dist (
        .clk(clk), .rst_n(rst_n), .vld(iss_reg),
        .x(loc_q[84:53]), .y(loc_q[52:21]), .cx(cx_reg), .cy(cy_reg),
        .r2(r2_reg), .cases(cas_q),
        .hit_vld(d_hit_vld), .hit_cases(d_hit_cases), .busy(d_busy)
    );

    assign out_valid = out_vld_reg;
    assign out_data = out_reg;

    always_comb
    begin
        nl = (loc_cnt_reg > 11'(ccnt_pkg::LOC_DEPTH)) ? 11'(ccnt_pkg::LOC_DEPTH) : loc_cnt_reg;
        nc = (clu_cnt_reg > 7'(ccnt_pkg::CLU_DEPTH)) ? 7'(ccnt_pkg::CLU_DEPTH) : clu_cnt_reg;
        hit = high_reg ? (sum_reg >= 32'(obs_reg)) : (sum_reg <= 32'(obs_reg));

        state_next = state_reg;
        pos_next = pos_reg;
        cur_next = cur_reg;
        label_next = label_reg;
        eval_next = eval_reg;
        clr_next = clr_reg;
        j_next = j_reg;
        k_next = k_reg;
        tid_next = tid_reg;
        trange_next = trange_reg;
        tvld_next = tvld_reg;
        iss_next = 1'b0;
        out_vld_next = out_vld_reg & ~out_ready;
        out_next = out_reg;
        rad_next = rad_reg;
        obs_next = obs_reg;
        high_next = high_reg;
        tcur_next = tcur_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        r2_next = r2_reg;
        sum_next = sum_reg;
        in_ready = 1'b0;
        loc_we = 1'b0;
        loc_waddr = in_data.index;
        loc_wdata = {in_data.coord_x, in_data.coord_y, in_data.end_index};
        loc_raddr = '0;
        cas_we = 1'b0;
        cas_waddr = '0;
        cas_wdata = '0;
        cas_raddr = '0;
        clu_we = 1'b0;
        clu_waddr = in_data.index[5:0];
        clu_wdata = {in_data.center_index, in_data.radius, in_data.observed_cases,
                     in_data.high_flag};
        clu_raddr = j_reg;
        tal_we = 1'b0;
        tal_waddr = j_reg;
        tal_wdata = '0;
        tal_raddr = j_reg;

        if (d_hit_vld)
        begin
            sum_next = sum_reg + 32'(d_hit_cases);
        end

        unique case (state_reg)
            ccnt_pkg::ST_CLEAR:
            begin
                cas_we = 1'b1;
                cas_waddr = clr_reg;
                if (clr_reg == 10'(ccnt_pkg::LOC_DEPTH - 1))
                begin
                    if (eval_reg)
                    begin
                        out_vld_next = 1'b1;
                        out_next = '{result_kind: ccnt_pkg::KIND_EVAL, cluster_id: '0,
                                     extreme_tally: '0};
                        pos_next = '0;
                        cur_next = '0;
                        eval_next = 1'b0;
                    end
                    state_next = ccnt_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 10'd1;
                end
            end
            ccnt_pkg::ST_IDLE:
            begin
                in_ready = ~out_vld_reg | out_ready;
                if (in_valid && in_ready)
                begin
                    unique case (in_data.func)
                        ccnt_pkg::F_LOAD_LOC:
                        begin
                            loc_we = 1'b1;
                        end
                        ccnt_pkg::F_LOAD_CLU:
                        begin
                            clu_we = (in_data.index < 10'(ccnt_pkg::CLU_DEPTH));
                        end
                        ccnt_pkg::F_LABEL:
                        begin
                            label_next = in_data.case_label;
                            state_next = ccnt_pkg::ST_L_READ;
                        end
                        ccnt_pkg::F_END_SIM:
                        begin
                            j_next = '0;
                            clr_next = '0;
                            if (nc == 7'd0)
                            begin
                                eval_next = 1'b1;
                                state_next = ccnt_pkg::ST_CLEAR;
                            end
                            else
                            begin
                                state_next = ccnt_pkg::ST_E_CLU;
                            end
                        end
                        ccnt_pkg::F_READ_TALLY:
                        begin
                            tal_raddr = in_data.index[5:0];
                            tid_next = in_data.index[5:0];
                            trange_next = (in_data.index < 10'(ccnt_pkg::CLU_DEPTH));
                            state_next = ccnt_pkg::ST_T_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ccnt_pkg::ST_T_READ:
            begin
                out_vld_next = 1'b1;
                out_next = '{result_kind: ccnt_pkg::KIND_TALLY, cluster_id: tid_reg,
                             extreme_tally: (trange_reg && tvld_reg[tid_reg]) ? tal_q : '0};
                state_next = ccnt_pkg::ST_IDLE;
            end
            ccnt_pkg::ST_L_READ:
            begin
                loc_raddr = cur_reg[9:0];
                state_next = (cur_reg < nl) ? ccnt_pkg::ST_L_CHK : ccnt_pkg::ST_L_FIN;
            end
            ccnt_pkg::ST_L_CHK:
            begin
                cas_raddr = cur_reg[9:0];
                if (pos_reg >= loc_q[20:0])
                begin
                    cur_next = cur_reg + 11'd1;
                    state_next = ccnt_pkg::ST_L_READ;
                end
                else
                begin
                    state_next = label_reg ? ccnt_pkg::ST_L_INC : ccnt_pkg::ST_L_FIN;
                end
            end
            ccnt_pkg::ST_L_INC:
            begin
                cas_we = 1'b1;
                cas_waddr = cur_reg[9:0];
                cas_wdata = (cas_q == '1) ? cas_q : cas_q + 21'd1;
                state_next = ccnt_pkg::ST_L_FIN;
            end
            ccnt_pkg::ST_L_FIN:
            begin
                if (pos_reg != '1)
                begin
                    pos_next = pos_reg + 21'd1;
                end
                state_next = ccnt_pkg::ST_IDLE;
            end
            ccnt_pkg::ST_E_CLU:
            begin
                state_next = ccnt_pkg::ST_E_CLU_W;
            end
            ccnt_pkg::ST_E_CLU_W:
            begin
                rad_next = clu_q[53:22];
                obs_next = clu_q[21:1];
                high_next = clu_q[0];
                tcur_next = tvld_reg[j_reg] ? tal_q : '0;
                sum_next = '0;
                loc_raddr = clu_q[63:54];
                state_next = ({1'b0, clu_q[63:54]} < nl) ? ccnt_pkg::ST_E_CEN
                                                        : ccnt_pkg::ST_E_DONE;
            end
            ccnt_pkg::ST_E_CEN:
            begin
                cx_next = loc_q[84:53];
                cy_next = loc_q[52:21];
                r2_next = 64'(rad_reg) * 64'(rad_reg);
                k_next = '0;
                state_next = ccnt_pkg::ST_E_SCAN;
            end
            ccnt_pkg::ST_E_SCAN:
            begin
                loc_raddr = k_reg;
                cas_raddr = k_reg;
                iss_next = 1'b1;
                if ({1'b0, k_reg} == nl - 11'd1)
                begin
                    state_next = ccnt_pkg::ST_E_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 10'd1;
                end
            end
            ccnt_pkg::ST_E_DRAIN:
            begin
                if (!iss_reg && !d_busy && !d_hit_vld)
                begin
                    state_next = ccnt_pkg::ST_E_DONE;
                end
            end
            ccnt_pkg::ST_E_DONE:
            begin
                if (hit && tcur_reg != '1)
                begin
                    tal_we = 1'b1;
                    tal_wdata = tcur_reg + 32'd1;
                    tvld_next[j_reg] = 1'b1;
                end
                if ({1'b0, j_reg} + 7'd1 == nc)
                begin
                    eval_next = 1'b1;
                    clr_next = '0;
                    state_next = ccnt_pkg::ST_CLEAR;
                end
                else
                begin
                    j_next = j_reg + 6'd1;
                    state_next = ccnt_pkg::ST_E_CLU;
                end
            end
            default:
            begin
                state_next = ccnt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccnt_pkg::ST_CLEAR;
            loc_cnt_reg <= 11'd1;
            clu_cnt_reg <= 7'd1;
            pos_reg <= '0;
            cur_reg <= '0;
            eval_reg <= 1'b0;
            clr_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            tvld_reg <= '0;
            iss_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == ccnt_pkg::CFG_LOC_COUNT)
                begin
                    loc_cnt_reg <= cfg_data;
                end
                else
                begin
                    clu_cnt_reg <= cfg_data[6:0];
                end
            end
            pos_reg <= pos_next;
            cur_reg <= cur_next;
            eval_reg <= eval_next;
            clr_reg <= clr_next;
            j_reg <= j_next;
            k_reg <= k_next;
            tvld_reg <= tvld_next;
            iss_reg <= iss_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        label_reg <= label_next;
        tid_reg <= tid_next;
        trange_reg <= trange_next;
        out_reg <= out_next;
        rad_reg <= rad_next;
        obs_reg <= obs_next;
        high_reg <= high_next;
        tcur_reg <= tcur_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        r2_reg <= r2_next;
        sum_reg <= sum_next;
    end

endmodule
